// ===== rtl/blit_pixel_format_converter_unit_defines.svh =====
// Assertion macros shared by the blitter pixel path.
`ifndef BLIT_PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH
`define BLIT_PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPFC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel path assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BPFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel path assertion failed");

`endif

// ===== rtl/blit_pfc_pkg.sv =====
package blit_pfc_pkg;

  // Palette geometry.
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);

  // Pixel format codes.
  localparam logic [1:0] FMT_PAL  = 2'd0;
  localparam logic [1:0] FMT_565  = 2'd1;
  localparam logic [1:0] FMT_8888 = 2'd2;

  // Input item operations.
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_FORMAT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TRANSPARENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_KEY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK         = 3'd4;

  // Configuration as seen by the pipeline; formats already normalized.
  typedef struct packed {
    logic [1:0]  source_format;
    logic [1:0]  dest_format;
    logic        skip_transparent;
    logic [31:0] transparent_key;
    logic [31:0] key_mask;
  } cfg_t;

  // First stage: accepted item with the source pixel trimmed to its format.
  typedef struct packed {
    logic        valid;
    logic        op;
    logic [31:0] src;
    logic [7:0]  entry_index;
    logic [23:0] entry_rgb;
  } s1_t;

  // Second stage: key decision and palette read data.
  typedef struct packed {
    logic        valid;
    logic        transparent;
    logic        pal_oor;
    logic [31:0] src;
    logic [23:0] pal_rgb;
  } s2_t;

  // Format code 3 behaves as ARGB8888.
  function automatic logic [1:0] norm_format(input logic [1:0] f);
    return (f == 2'd3) ? FMT_8888 : f;
  endfunction

  // Bits of a pixel that belong to a format.
  function automatic logic [31:0] format_mask(input logic [1:0] f);
    logic [31:0] m;
    case (f)
      FMT_PAL: m = 32'h0000_00ff;
      FMT_565: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // x*255/63 for a 6-bit VGA component: 4x plus floor(x/21).
  function automatic logic [7:0] vga_scale(input logic [5:0] x);
    logic [1:0] q;
    if (x >= 6'd63) begin
      q = 2'd3;
    end else if (x >= 6'd42) begin
      q = 2'd2;
    end else if (x >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {x, 2'b00} + {6'd0, q};
  endfunction

endpackage

// ===== rtl/blit_pfc_front.sv =====
module blit_pfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  blit_pfc_pkg::cfg_t  cfg,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic [31:0]         in_source_pixel,
  input  logic [7:0]          in_entry_index,
  input  logic [5:0]          in_entry_red,
  input  logic [5:0]          in_entry_green,
  input  logic [5:0]          in_entry_blue,
  output blit_pfc_pkg::s1_t   s1
);

  logic        valid_r;
  logic        op_r;
  logic [31:0] src_r;
  logic [7:0]  entry_index_r;
  logic [23:0] entry_rgb_r;
  logic [23:0] entry_rgb_nxt;

  // Palette components are scaled to 8 bits on the way in.
  assign entry_rgb_nxt = {blit_pfc_pkg::vga_scale(in_entry_red),
                          blit_pfc_pkg::vga_scale(in_entry_green),
                          blit_pfc_pkg::vga_scale(in_entry_blue)};

  // Stage valid follows the input whenever the pipeline moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  // Payload capture; the source pixel keeps only its format's bits.
  always_ff @(posedge clk) begin
    if (advance) begin
      op_r          <= in_op;
      src_r         <= in_source_pixel & blit_pfc_pkg::format_mask(cfg.source_format);
      entry_index_r <= in_entry_index;
      entry_rgb_r   <= entry_rgb_nxt;
    end
  end

  assign s1.valid       = valid_r;
  assign s1.op          = op_r;
  assign s1.src         = src_r;
  assign s1.entry_index = entry_index_r;
  assign s1.entry_rgb   = entry_rgb_r;

endmodule

// ===== rtl/blit_pfc_palette.sv =====
module blit_pfc_palette (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  blit_pfc_pkg::cfg_t  cfg,
  input  blit_pfc_pkg::s1_t   s1,
  output blit_pfc_pkg::s2_t   s2
);

  localparam int IDX_W = blit_pfc_pkg::PAL_IDX_W;

  logic [23:0] mem [blit_pfc_pkg::PAL_ENTRIES];

  logic        valid_r;
  logic        transparent_r;
  logic        pal_oor_r;
  logic [31:0] src_r;
  logic [23:0] rd_data_r;
  logic        wr_en;
  logic        wr_in_range;
  logic        rd_oor;

  // Range checks against the palette depth.
  assign wr_in_range = {1'b0, s1.entry_index} < 9'(blit_pfc_pkg::PAL_ENTRIES);
  assign rd_oor      = {1'b0, s1.src[7:0]} >= 9'(blit_pfc_pkg::PAL_ENTRIES);
  assign wr_en       = advance && s1.valid && (s1.op == blit_pfc_pkg::OP_PALETTE) &&
                       wr_in_range;

  // Palette write; an entry write lands before any later pixel reads it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1.entry_index[IDX_W-1:0]] <= s1.entry_rgb;
    end
  end

  // Registered palette read, indexed by the low byte of the source pixel.
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data_r <= mem[s1.src[IDX_W-1:0]];
    end
  end

  // Only convert items go on; palette writes end here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1.valid && (s1.op == blit_pfc_pkg::OP_CONVERT);
    end
  end

  // Transparent key compare on the masked source pixel.
  always_ff @(posedge clk) begin
    if (advance) begin
      transparent_r <= cfg.skip_transparent &&
                       ((s1.src & cfg.key_mask) == cfg.transparent_key);
      pal_oor_r     <= rd_oor;
      src_r         <= s1.src;
    end
  end

  assign s2.valid       = valid_r;
  assign s2.transparent = transparent_r;
  assign s2.pal_oor     = pal_oor_r;
  assign s2.src         = src_r;
  assign s2.pal_rgb     = rd_data_r;

endmodule

// ===== rtl/blit_pfc_pack.sv =====
module blit_pfc_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  blit_pfc_pkg::cfg_t  cfg,
  input  blit_pfc_pkg::s2_t   s2,
  output logic                out_valid,
  output logic                out_write_enable,
  output logic [31:0]         out_dest_pixel
);

  logic        valid_r;
  logic        write_enable_r;
  logic [31:0] dest_pixel_r;
  logic        write_enable_nxt;
  logic [31:0] dest_pixel_nxt;

  // Expand to ARGB, then pack into the destination format.
  always_comb begin
    logic [1:0]  sf;
    logic [1:0]  df;
    logic [7:0]  a;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] pix;
    sf = cfg.source_format;
    df = cfg.dest_format;
    case (sf)
      blit_pfc_pkg::FMT_PAL: begin
        a = 8'hff;
        if (s2.pal_oor) begin
          r = 8'h00;
          g = 8'h00;
          b = 8'h00;
        end else begin
          r = s2.pal_rgb[23:16];
          g = s2.pal_rgb[15:8];
          b = s2.pal_rgb[7:0];
        end
      end
      blit_pfc_pkg::FMT_565: begin
        a = 8'hff;
        r = {s2.src[15:11], s2.src[15:13]};
        g = {s2.src[10:5], s2.src[10:9]};
        b = {s2.src[4:0], s2.src[4:2]};
      end
      default: begin
        a = s2.src[31:24];
        r = s2.src[23:16];
        g = s2.src[15:8];
        b = s2.src[7:0];
      end
    endcase
    if (df == blit_pfc_pkg::FMT_PAL) begin
      pix = {24'd0, s2.src[7:0]};
    end else if (df == sf) begin
      pix = s2.src;
    end else if (df == blit_pfc_pkg::FMT_8888) begin
      pix = {a, r, g, b};
    end else begin
      pix = {16'd0, r[7:3], g[7:2], b[7:3]};
    end
    if (s2.transparent) begin
      write_enable_nxt = 1'b0;
      dest_pixel_nxt   = 32'd0;
    end else begin
      write_enable_nxt = 1'b1;
      dest_pixel_nxt   = pix & blit_pfc_pkg::format_mask(df);
    end
  end

  // Output register; holds while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_enable_r <= write_enable_nxt;
      dest_pixel_r   <= dest_pixel_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_write_enable = write_enable_r;
  assign out_dest_pixel   = dest_pixel_r;

endmodule

// ===== rtl/blit_pixel_format_converter_unit.sv =====
// Per-pixel conversion path of a sprite blitter. It takes one item per clock
// while in_stall is low, and a convert item gives its result after all stages; a
// palette-write item gives no result. The three register stages are input
// capture with format trim and palette scaling, key compare with the palette
// read (a 256 x 24 memory with one write and one registered read port), and
// the pack into the destination format. All stages move together: out_stall on
// a valid result holds them all and shows on in_stall in the same cycle. Write the
// palette before converting palette pixels; unwritten entries read undefined.
`include "blit_pixel_format_converter_unit_defines.svh"

module blit_pixel_format_converter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [blit_pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blit_pfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [31:0]                         in_source_pixel,
  input  logic [7:0]                          in_entry_index,
  input  logic [5:0]                          in_entry_red,
  input  logic [5:0]                          in_entry_green,
  input  logic [5:0]                          in_entry_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_write_enable,
  output logic [31:0]                         out_dest_pixel
);

  logic [1:0]        source_format_r;
  logic [1:0]        dest_format_r;
  logic              skip_transparent_r;
  logic [31:0]       transparent_key_r;
  logic [31:0]       key_mask_r;
  logic              advance;
  blit_pfc_pkg::cfg_t cfg;
  blit_pfc_pkg::s1_t  s1;
  blit_pfc_pkg::s2_t  s2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_format_r    <= blit_pfc_pkg::FMT_8888;
      dest_format_r      <= blit_pfc_pkg::FMT_8888;
      skip_transparent_r <= 1'b0;
      transparent_key_r  <= 32'd0;
      key_mask_r         <= 32'h0000_00ff;
    end else if (cfg_we) begin
      case (cfg_index)
        blit_pfc_pkg::CFG_SOURCE_FORMAT:    source_format_r    <= cfg_wdata[1:0];
        blit_pfc_pkg::CFG_DEST_FORMAT:      dest_format_r      <= cfg_wdata[1:0];
        blit_pfc_pkg::CFG_SKIP_TRANSPARENT: skip_transparent_r <= cfg_wdata[0];
        blit_pfc_pkg::CFG_TRANSPARENT_KEY:  transparent_key_r  <= cfg_wdata[31:0];
        blit_pfc_pkg::CFG_KEY_MASK:         key_mask_r         <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.source_format    = blit_pfc_pkg::norm_format(source_format_r);
  assign cfg.dest_format      = blit_pfc_pkg::norm_format(dest_format_r);
  assign cfg.skip_transparent = skip_transparent_r;
  assign cfg.transparent_key  = transparent_key_r;
  assign cfg.key_mask         = key_mask_r;

  // The pipeline moves unless a finished result is waiting on the consumer.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  blit_pfc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_source_pixel (in_source_pixel),
    .in_entry_index  (in_entry_index),
    .in_entry_red    (in_entry_red),
    .in_entry_green  (in_entry_green),
    .in_entry_blue   (in_entry_blue),
    .s1              (s1)
  );

  blit_pfc_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .s1      (s1),
    .s2      (s2)
  );

  blit_pfc_pack u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .cfg              (cfg),
    .s2               (s2),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_pixel   (out_dest_pixel)
  );

  // Input backpressure comes only from a waiting result.
  `BPFC_ASSERT_IMPL(a_stall_source, in_stall, out_valid && out_stall)
  // A transparent result carries a zero pixel.
  `BPFC_ASSERT_IMPL(a_transparent_zero, out_valid && !out_write_enable, out_dest_pixel == 32'd0)
  // A convert transfer occupies the first stage on the next cycle.
  `BPFC_ASSERT_NEXT(a_convert_enters, in_valid && !in_stall && (in_op == blit_pfc_pkg::OP_CONVERT), s1.valid && (s1.op == blit_pfc_pkg::OP_CONVERT))
  // A palette write never moves on into the result stages.
  `BPFC_ASSERT_NEXT(a_palette_drops, s1.valid && (s1.op == blit_pfc_pkg::OP_PALETTE) && advance, !s2.valid)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Format code 3 is not named in the package; the block treats it as ARGB8888.
  localparam logic [1:0] FMT_ALIAS_8888 = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int DIRECTED_ROWS = 26;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] dest_pixel;
  } pixel_result_t;

  // One directed row: the configuration it needs, the item, and an optional
  // hand-written expectation.
  typedef struct packed {
    logic [1:0]  sf;
    logic [1:0]  df;
    logic        skip;
    logic [31:0] key;
    logic [31:0] mask;
    logic        op;
    logic [31:0] pixel;
    logic [7:0]  idx;
    logic [5:0]  red;
    logic [5:0]  green;
    logic [5:0]  blue;
    logic        typed;
    logic        we;
    logic [31:0] pix;
  } blit_case_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [blit_pfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [blit_pfc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [31:0] in_source_pixel;
  logic [7:0]  in_entry_index;
  logic [5:0]  in_entry_red;
  logic [5:0]  in_entry_green;
  logic [5:0]  in_entry_blue;
  logic        out_valid;
  logic        out_stall;
  logic        out_write_enable;
  logic [31:0] out_dest_pixel;

  // Predictor copy of the configuration and the palette.
  logic [1:0]  cur_src_fmt = blit_pfc_pkg::FMT_8888;
  logic [1:0]  cur_dst_fmt = blit_pfc_pkg::FMT_8888;
  logic        cur_skip = 1'b0;
  logic [31:0] cur_key = 32'h0000_0000;
  logic [31:0] cur_mask = 32'h0000_00ff;
  logic [23:0] palette_rgb [blit_pfc_pkg::PAL_ENTRIES];

  pixel_result_t expected_pixels [$];
  pixel_result_t seen_pixel;
  int fail_count = 0;
  int pixels_checked = 0;
  int transparent_checked = 0;
  int items_sent = 0;
  int palette_writes = 0;
  int idle_cycles = 0;
  int stall_len = 0;
  int stall_pick;
  bit steady = 1'b0;

  blit_case_t directed_cases [DIRECTED_ROWS] = '{
    // Reset configuration: straight ARGB8888 copy.
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'hffff_ffff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'hffff_ffff},
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_0000, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_0000},
    // Palette loads: black, white and one mid value.
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_PALETTE, 32'h0, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b0, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_PALETTE, 32'h0, 8'hff, 6'd63, 6'd63, 6'd63,
      1'b0, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_PALETTE, 32'h0, 8'h5a, 6'd21, 6'd42, 6'd1,
      1'b0, 1'b0, 32'h0},
    // Palette source into ARGB8888 and RGB565.
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'hffff_ff00, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'hff00_0000},
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_00ff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'hffff_ffff},
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_005a, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b0, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_565, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_00ff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_ffff},
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_565, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_005a, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b0, 1'b0, 32'h0},
    // Palette destination keeps the low byte.
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_PAL, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h1234_56ab, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_00ab},
    // RGB565 source.
    '{blit_pfc_pkg::FMT_565, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_ffff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'hffff_ffff},
    '{blit_pfc_pkg::FMT_565, blit_pfc_pkg::FMT_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'habcd_1234, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b0, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_565, blit_pfc_pkg::FMT_565, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'hdead_beef, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_beef},
    '{blit_pfc_pkg::FMT_565, blit_pfc_pkg::FMT_PAL, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_1234, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_0034},
    // ARGB8888 source into the narrower formats.
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_565, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'hffff_ffff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_ffff},
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_PAL, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h1234_5678, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_0078},
    // Format code 3 acts as ARGB8888 on both sides.
    '{FMT_ALIAS_8888, FMT_ALIAS_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'hcafe_f00d, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'hcafe_f00d},
    '{FMT_ALIAS_8888, blit_pfc_pkg::FMT_565, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'hffff_ffff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h0000_ffff},
    '{blit_pfc_pkg::FMT_565, FMT_ALIAS_8888, 1'b0, 32'h0, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_ffff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'hffff_ffff},
    // Transparent key: hit, near miss, and the mask and key extremes.
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b1, 32'h42, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h1234_5642, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b1, 32'h42, 32'hff,
      blit_pfc_pkg::OP_CONVERT, 32'h1234_5643, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b1, 32'h1234_5643},
    '{blit_pfc_pkg::FMT_8888, blit_pfc_pkg::FMT_8888, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
      blit_pfc_pkg::OP_CONVERT, 32'hffff_ffff, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_PAL, blit_pfc_pkg::FMT_8888, 1'b1, 32'h0, 32'h0,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_0077, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b0, 32'h0},
    // The key compares the pixel after the format trim.
    '{blit_pfc_pkg::FMT_565, blit_pfc_pkg::FMT_8888, 1'b1, 32'h1234, 32'hffff_ffff,
      blit_pfc_pkg::OP_CONVERT, 32'hffff_1234, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b1, 1'b0, 32'h0},
    '{blit_pfc_pkg::FMT_565, blit_pfc_pkg::FMT_8888, 1'b0, 32'h1234, 32'hffff_ffff,
      blit_pfc_pkg::OP_CONVERT, 32'h0000_1234, 8'h00, 6'd0, 6'd0, 6'd0,
      1'b0, 1'b0, 32'h0}
  };

  blit_pixel_format_converter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_source_pixel  (in_source_pixel),
    .in_entry_index   (in_entry_index),
    .in_entry_red     (in_entry_red),
    .in_entry_green   (in_entry_green),
    .in_entry_blue    (in_entry_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_dest_pixel   (out_dest_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bits of a pixel that a format keeps; code 3 keeps all of them.
  function automatic logic [31:0] fmt_bits(input logic [1:0] f);
    logic [31:0] m;
    case (f)
      blit_pfc_pkg::FMT_PAL: m = 32'h0000_00ff;
      blit_pfc_pkg::FMT_565: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // Six-bit VGA component stretched to eight bits.
  function automatic logic [7:0] stretch_vga(input logic [5:0] c);
    int v;
    v = (int'(c) * 255) / 63;
    return v[7:0];
  endfunction

  // Destination pixel that the current configuration makes of one source pixel.
  function automatic pixel_result_t convert_pixel(input logic [31:0] raw);
    logic [1:0]  sfmt;
    logic [1:0]  dfmt;
    logic [31:0] src;
    logic [31:0] pix;
    logic [23:0] rgb;
    logic [7:0]  a, r, g, b;
    pixel_result_t res;
    sfmt = (cur_src_fmt == FMT_ALIAS_8888) ? blit_pfc_pkg::FMT_8888 : cur_src_fmt;
    dfmt = (cur_dst_fmt == FMT_ALIAS_8888) ? blit_pfc_pkg::FMT_8888 : cur_dst_fmt;
    src = raw & fmt_bits(sfmt);
    if (cur_skip && ((src & cur_mask) == cur_key)) begin
      res.write_enable = 1'b0;
      res.dest_pixel = 32'd0;
      return res;
    end
    if (dfmt == blit_pfc_pkg::FMT_PAL) begin
      pix = {24'd0, src[7:0]};
    end else if (dfmt == sfmt) begin
      pix = src;
    end else begin
      // Expand to A, R, G, B first.
      if (sfmt == blit_pfc_pkg::FMT_PAL) begin
        rgb = palette_rgb[src[7:0]];
        a = 8'hff;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
      end else if (sfmt == blit_pfc_pkg::FMT_565) begin
        a = 8'hff;
        r = {src[15:11], src[15:13]};
        g = {src[10:5], src[10:9]};
        b = {src[4:0], src[4:2]};
      end else begin
        {a, r, g, b} = src;
      end
      if (dfmt == blit_pfc_pkg::FMT_8888) begin
        pix = {a, r, g, b};
      end else begin
        pix = {16'd0, r[7:3], g[7:2], b[7:3]};
      end
    end
    res.write_enable = 1'b1;
    res.dest_pixel = pix & fmt_bits(dfmt);
    return res;
  endfunction

  // Wait until every expected pixel has come back and the pipeline is empty.
  task automatic drain_pipeline();
    int free_cycles;
    free_cycles = 0;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    while (free_cycles < 6) begin
      @(posedge clk);
      if (!out_stall) free_cycles++;
    end
  endtask

  // Write all five registers while the block is idle.
  task automatic apply_config(input logic [1:0] sf, input logic [1:0] df, input logic skip,
                              input logic [31:0] key, input logic [31:0] mask);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= blit_pfc_pkg::CFG_SOURCE_FORMAT;
    cfg_wdata <= {30'd0, sf};
    @(posedge clk);
    cfg_index <= blit_pfc_pkg::CFG_DEST_FORMAT;
    cfg_wdata <= {30'd0, df};
    @(posedge clk);
    cfg_index <= blit_pfc_pkg::CFG_SKIP_TRANSPARENT;
    cfg_wdata <= {31'd0, skip};
    @(posedge clk);
    cfg_index <= blit_pfc_pkg::CFG_TRANSPARENT_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_index <= blit_pfc_pkg::CFG_KEY_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_src_fmt = sf;
    cur_dst_fmt = df;
    cur_skip = skip;
    cur_key = key;
    cur_mask = mask;
  endtask

  // One input transfer after a random gap; records what it should produce.
  task automatic send_item(input logic op, input logic [31:0] pixel, input logic [7:0] idx,
                           input logic [5:0] red, input logic [5:0] green,
                           input logic [5:0] blue, input logic typed,
                           input pixel_result_t typed_res);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_source_pixel <= pixel;
    in_entry_index <= idx;
    in_entry_red <= red;
    in_entry_green <= green;
    in_entry_blue <= blue;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (op == blit_pfc_pkg::OP_PALETTE) begin
      palette_rgb[idx] = {stretch_vga(red), stretch_vga(green), stretch_vga(blue)};
      palette_writes++;
    end else if (typed) begin
      expected_pixels.push_back(typed_res);
    end else begin
      expected_pixels.push_back(convert_pixel(pixel));
    end
  endtask

  // Result side: random stall pattern, off while a steady phase runs.
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_stall <= 1'b0;
      stall_len <= 0;
    end else if (stall_len != 0) begin
      stall_len <= stall_len - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 65) begin
        out_stall <= 1'b0;
        stall_len <= $urandom_range(0, 4);
      end else if (stall_pick < 93) begin
        out_stall <= 1'b1;
        stall_len <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_len <= $urandom_range(8, 40);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: write_enable %0b dest_pixel %h",
                 $time, out_write_enable, out_dest_pixel);
        fail_count++;
      end else begin
        seen_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (!seen_pixel.write_enable) transparent_checked++;
        if (out_write_enable !== seen_pixel.write_enable) begin
          $display("%0t: write_enable expected %0b actual %0b",
                   $time, seen_pixel.write_enable, out_write_enable);
          fail_count++;
        end
        if (out_dest_pixel !== seen_pixel.dest_pixel) begin
          $display("%0t: dest_pixel expected %h actual %h",
                   $time, seen_pixel.dest_pixel, out_dest_pixel);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    blit_case_t row;
    pixel_result_t hand_res;
    pixel_result_t none_res;
    logic [1:0]  sf, df;
    logic        skip;
    logic [31:0] key, mask, pixel;
    int i, phase, n, pick;

    none_res = '0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= blit_pfc_pkg::CFG_SOURCE_FORMAT;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_op <= blit_pfc_pkg::OP_CONVERT;
    in_source_pixel <= '0;
    in_entry_index <= '0;
    in_entry_red <= '0;
    in_entry_green <= '0;
    in_entry_blue <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; the first ones run on the reset configuration.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_cases[i];
      if ({row.sf, row.df, row.skip, row.key, row.mask} !=
          {cur_src_fmt, cur_dst_fmt, cur_skip, cur_key, cur_mask}) begin
        apply_config(row.sf, row.df, row.skip, row.key, row.mask);
      end
      hand_res.write_enable = row.we;
      hand_res.dest_pixel = row.pix;
      send_item(row.op, row.pixel, row.idx, row.red, row.green, row.blue, row.typed,
                hand_res);
    end

    // Fill the whole palette so that no later lookup hits an unwritten entry.
    for (i = 0; i < blit_pfc_pkg::PAL_ENTRIES; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(blit_pfc_pkg::OP_PALETTE, $urandom, i[7:0], 6'd0, 6'd0, 6'd0, 1'b0,
                  none_res);
      end else if (pick == 1) begin
        send_item(blit_pfc_pkg::OP_PALETTE, $urandom, i[7:0], 6'd63, 6'd63, 6'd63, 1'b0,
                  none_res);
      end else begin
        send_item(blit_pfc_pkg::OP_PALETTE, $urandom, i[7:0], 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0, none_res);
      end
    end

    // Random phases, each with its own configuration.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      sf = 2'($urandom_range(0, 3));
      df = 2'($urandom_range(0, 3));
      skip = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: mask = 32'h0000_0000;
        1: mask = 32'h0000_00ff;
        2: mask = 32'h0000_ffff;
        3: mask = 32'hffff_ffff;
        default: mask = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: key = 32'h0000_0000;
        1: key = 32'hffff_ffff;
        default: key = $urandom & fmt_bits(sf) & mask;
      endcase
      apply_config(sf, df, skip, key, mask);
      steady <= (phase % 4 == 3);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_item(blit_pfc_pkg::OP_PALETTE, $urandom, 8'($urandom_range(0, 255)),
                    6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)), 1'b0, none_res);
        end else begin
          if (pick < 40) pixel = key | ($urandom & ~mask);
          else if (pick < 44) pixel = 32'h0000_0000;
          else if (pick < 48) pixel = 32'hffff_ffff;
          else pixel = $urandom;
          send_item(blit_pfc_pkg::OP_CONVERT, pixel, 8'($urandom),
                    6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)), 1'b0, none_res);
        end
      end
      steady <= 1'b0;
    end

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_pixels.size());
      fail_count++;
    end
    $display("Run covered %0d input transfers (%0d palette loads): %0d directed rows, then %0d random configurations.",
             items_sent, palette_writes, DIRECTED_ROWS, RANDOM_PHASES);
    $display("Checked %0d pixel results, %0d of them transparent; %0d mismatches.",
             pixels_checked, transparent_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
